// File: rtl/psft_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the priority store-and-forward table.
// Depends on nothing; the jitter unit, datapath, controller and top import it.
package psft_pkg;

  localparam int CAPACITY_DEF = 64;

  // Command codes of an input item.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_TICK   = 2'd1,
    OP_REPORT = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // Result status codes.
  localparam logic [1:0] ST_STORED = 2'd0;
  localparam logic [1:0] ST_DUP    = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMERGENCY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_LIMIT = 1'd1;
  localparam int CFG_DATA_W = 8;
  localparam logic [7:0] FWD_LIMIT_RST = 8'd3;

  // Timing constants in milliseconds, and the forwarding count ceiling.
  localparam logic [21:0] HOUR_MS    = 22'd3600000;
  localparam logic [21:0] HALF_LIMIT = 22'd30000;
  localparam logic [14:0] JITTER_MOD = 15'd15000;
  localparam logic [7:0]  FWD_MAX    = 8'hff;

  // Minutes from a millisecond span: (span >> 5) / 1875 by reciprocal.
  localparam int MIN_PRE_SHIFT = 5;
  localparam int MIN_SHIFT     = 38;
  localparam logic [63:0] MIN_MAGIC_W = ((64'd1 << MIN_SHIFT) + 64'd1874) / 64'd1875;
  localparam logic [27:0] MIN_MAGIC   = MIN_MAGIC_W[27:0];

  // Jitter quotient: (h >> 3) / 1875 by reciprocal, exact for any 32-bit h.
  localparam int JIT_PRE_SHIFT = 3;
  localparam int JIT_SHIFT     = 40;
  localparam logic [63:0] JIT_MAGIC_W = ((64'd1 << JIT_SHIFT) + 64'd1874) / 64'd1875;
  localparam logic [29:0] JIT_MAGIC   = JIT_MAGIC_W[29:0];

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [1:0]  priority_req;
    logic [7:0]  ttl_hours;
    logic        to_self;
    logic [31:0] now_ms;
    logic [5:0]  slot_in;
    logic        sent_ok;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       slot_valid;
    logic [5:0] slot_out;
    logic       evicted_valid;
    logic [5:0] evicted_slot;
    logic [6:0] expired_count;
    logic [6:0] occupancy;
  } out_t;

  // Per-slot fields fixed at insert time.
  typedef struct packed {
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [1:0]  prio;
    logic [7:0]  ttl;
    logic        to_self;
    logic [13:0] jitter;
    logic [31:0] first_seen;
  } entry_st_t;

  // Per-slot forwarding state.
  typedef struct packed {
    logic [31:0] last_fwd;
    logic [7:0]  fwd_cnt;
  } entry_dy_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT_JIT,
    S_RPT_RD,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_vld;
    logic rpt_rd;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic jit_done;
  } dp_stat_t;

  function automatic logic [21:0] base_interval(input logic [1:0] prio);
    logic [21:0] r;
    case (prio)
      2'd0:    r = 22'd20000;
      2'd1:    r = 22'd60000;
      2'd2:    r = 22'd180000;
      default: r = 22'd600000;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/psft_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
// Depends on nothing.
module psft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/psft_jitter.sv
`timescale 1ns / 1ps
// Id jitter unit: byte hash h = h*33 ^ byte over 16 id bytes, then h mod 15000
// by reciprocal multiply, quotient then remainder step. Depends on psft_pkg.
module psft_jitter import psft_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  id_high,
  input  logic [63:0]  id_low,
  output logic         done,
  output logic [13:0]  jitter
);

  localparam logic [5:0] HASH_STEPS = 6'd16;
  localparam logic [5:0] QUOT_STEP  = 6'd16;
  localparam logic [5:0] LAST_STEP  = 6'd17;

  logic         run_r, run_nxt;
  logic         done_r, done_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic [31:0]  h_r, h_nxt;
  logic [127:0] sh_r, sh_nxt;
  logic [18:0]  q_r, q_nxt;
  logic [13:0]  rem_r, rem_nxt;
  logic [58:0]  qprod;
  logic [31:0]  qmul, rdiff;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    h_nxt    = h_r;
    sh_nxt   = sh_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    qprod    = {30'd0, h_r[31:JIT_PRE_SHIFT]} * {29'd0, JIT_MAGIC};
    qmul     = {13'd0, q_r} * {17'd0, JITTER_MOD};
    rdiff    = h_r - qmul;
    if (start) begin
      run_nxt  = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      h_nxt    = '0;
      sh_nxt   = {id_high, id_low};
      q_nxt    = '0;
      rem_nxt  = '0;
    end else if (run_r) begin
      if (cnt_r < HASH_STEPS) begin
        h_nxt  = ((h_r << 5) + h_r) ^ {24'd0, sh_r[127:120]};
        sh_nxt = sh_r << 8;
      end else if (cnt_r == QUOT_STEP) begin
        q_nxt = qprod[58:JIT_SHIFT];
      end else begin
        // remainder is below 15000, so 14 bits hold it
        rem_nxt = rdiff[13:0];
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == LAST_STEP) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    h_r   <= h_nxt;
    sh_r  <= sh_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done   = done_r;
  assign jitter = rem_r;

endmodule

// File: rtl/psft_dpath.sv
`timescale 1ns / 1ps
// Datapath: slot memories, used bits, scan pipeline, search registers, commit.
// Depends on psft_pkg, psft_ram and psft_jitter.
module psft_dpath import psft_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int SW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_t                   in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  dp_cmd_t               cmd,
  input  logic [SW-1:0]         scan_addr,
  output dp_stat_t              stat,
  output logic                  out_valid,
  output out_t                  out_data
);

  // configuration
  logic       emerg_r;
  logic [7:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emerg_r <= 1'b0;
      limit_r <= FWD_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EMERGENCY: emerg_r <= cfg_wdata[0];
        CFG_FWD_LIMIT: limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // latched item
  op_t         op_r;
  logic [63:0] hi_r, lo_r;
  logic [1:0]  prio_r;
  logic [7:0]  ttl_r;
  logic        self_r;
  logic [31:0] now_r;
  logic [5:0]  slot_in_r;
  logic        ok_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= op_t'(in_data.command);
      hi_r      <= in_data.id_high;
      lo_r      <= in_data.id_low;
      prio_r    <= in_data.priority_req;
      ttl_r     <= in_data.ttl_hours;
      self_r    <= in_data.to_self;
      now_r     <= in_data.now_ms;
      slot_in_r <= in_data.slot_in;
      ok_r      <= in_data.sent_ok;
    end
  end

  logic [13:0] jit;
  logic        jit_done;

  psft_jitter u_jit (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.load),
    .id_high (in_data.id_high),
    .id_low  (in_data.id_low),
    .done    (jit_done),
    .jitter  (jit)
  );

  assign stat.jit_done = jit_done;

  // report slot range check
  logic [SW+5:0] slot_ext;
  logic          rpt_in_range;
  logic [SW-1:0] rpt_idx;

  assign slot_ext     = {{SW{1'b0}}, slot_in_r};
  assign rpt_in_range = slot_ext < (SW+6)'(CAPACITY);
  assign rpt_idx      = slot_ext[SW-1:0];

  // memories
  entry_st_t st_rdata, st_wdata;
  entry_dy_t dy_rdata, dy_wdata;
  logic      st_we, dy_we;
  logic [SW-1:0] st_waddr, dy_waddr, raddr;

  assign raddr = cmd.rpt_rd ? rpt_idx : scan_addr;

  psft_ram #(.WIDTH($bits(entry_st_t)), .DEPTH(CAPACITY)) u_st_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(raddr), .rdata(st_rdata)
  );

  psft_ram #(.WIDTH($bits(entry_dy_t)), .DEPTH(CAPACITY)) u_dy_ram (
    .clk(clk), .we(dy_we), .waddr(dy_waddr), .wdata(dy_wdata),
    .raddr(raddr), .rdata(dy_rdata)
  );

  logic          used_r [CAPACITY];
  logic [CW-1:0] count_r;

  // scan stage 1: memory data arrives
  logic          v1_r;
  logic [SW-1:0] idx1_r;
  logic [21:0]   base1;
  logic [22:0]   thr1;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= cmd.scan_vld;
    idx1_r <= scan_addr;
  end

  always_comb begin
    base1 = base_interval(st_rdata.prio);
    if (emerg_r && base1 > HALF_LIMIT) base1 = base1 >> 1;
    if (dy_rdata.fwd_cnt >= limit_r) base1 = HOUR_MS;
    thr1 = {1'b0, base1} + {9'd0, st_rdata.jitter};
  end

  // stage 2 registers
  logic          v2_r, used2_r, match2_r, self2_r;
  logic [SW-1:0] idx2_r;
  logic [1:0]    prio2_r;
  logic [7:0]    fwd2_r;
  logic [31:0]   last2_r, diff2_r, el2_r;
  logic [22:0]   thr2_r;
  logic [29:0]   lim2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    idx2_r   <= idx1_r;
    used2_r  <= used_r[idx1_r];
    match2_r <= (st_rdata.id_high == hi_r) && (st_rdata.id_low == lo_r);
    self2_r  <= st_rdata.to_self;
    prio2_r  <= st_rdata.prio;
    fwd2_r   <= dy_rdata.fwd_cnt;
    last2_r  <= dy_rdata.last_fwd;
    diff2_r  <= now_r - st_rdata.first_seen;
    el2_r    <= now_r - dy_rdata.last_fwd;
    thr2_r   <= thr1;
    lim2_r   <= {22'd0, st_rdata.ttl} * {8'd0, HOUR_MS};
  end

  // stage 2: expiry, due check, age in minutes
  logic        expire2, due2;
  logic [54:0] prod2;

  assign expire2 = v2_r && (op_r == OP_TICK) && used2_r && (lim2_r != 30'd0) &&
                   (diff2_r >= {2'd0, lim2_r});
  assign due2    = (last2_r == 32'd0) || (el2_r >= {9'd0, thr2_r});
  assign prod2   = {28'd0, diff2_r[31:MIN_PRE_SHIFT]} * {27'd0, MIN_MAGIC};

  logic          v3_r, used3_r, live3_r, match3_r, self3_r, due3_r;
  logic [SW-1:0] idx3_r;
  logic [1:0]    prio3_r;
  logic [7:0]    fwd3_r;
  logic [31:0]   last3_r;
  logic [16:0]   age3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    idx3_r   <= idx2_r;
    used3_r  <= used2_r;
    live3_r  <= used2_r && !expire2;
    match3_r <= match2_r;
    self3_r  <= self2_r;
    due3_r   <= due2;
    prio3_r  <= prio2_r;
    fwd3_r   <= fwd2_r;
    last3_r  <= last2_r;
    age3_r   <= prod2[54:MIN_SHIFT];
  end

  // stage 3: search registers
  logic          bf_r, dup_r, ff_r;
  logic [1:0]    bp_r;
  logic [16:0]   ba_r;
  logic [SW-1:0] bs_r, fs_r;
  logic [7:0]    bfwd_r;
  logic [31:0]   blast_r;
  logic [CW-1:0] xcnt_r;
  logic          take3, older3;

  always_comb begin
    older3 = (prio3_r == bp_r) && (age3_r > ba_r);
    take3  = 1'b0;
    if (v3_r && live3_r) begin
      if (op_r == OP_INSERT) begin
        take3 = (prio3_r >= prio_r) && (!bf_r || prio3_r > bp_r || older3);
      end else if (op_r == OP_TICK) begin
        take3 = !self3_r && due3_r && (!bf_r || prio3_r < bp_r || older3);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      bf_r   <= 1'b0;
      dup_r  <= 1'b0;
      ff_r   <= 1'b0;
      xcnt_r <= '0;
    end else begin
      if (take3) bf_r <= 1'b1;
      if (v3_r && op_r == OP_INSERT && live3_r && match3_r) dup_r <= 1'b1;
      if (v3_r && op_r == OP_INSERT && !used3_r && !ff_r) ff_r <= 1'b1;
      if (expire2) xcnt_r <= xcnt_r + CW'(1);
    end
    if (take3) begin
      bp_r    <= prio3_r;
      ba_r    <= age3_r;
      bs_r    <= idx3_r;
      bfwd_r  <= fwd3_r;
      blast_r <= last3_r;
    end
    if (v3_r && !used3_r && !ff_r) fs_r <= idx3_r;
  end

  // commit
  logic          full, place, set_used, cnt_inc, ev, sv;
  logic [SW-1:0] tgt, sidx;
  logic [1:0]    res_status;
  logic [7:0]    fwd_inc;

  assign full    = count_r == CW'(CAPACITY);
  assign fwd_inc = (dy_rdata.fwd_cnt == FWD_MAX) ? FWD_MAX : dy_rdata.fwd_cnt + 8'd1;

  always_comb begin
    place      = 1'b0;
    set_used   = 1'b0;
    cnt_inc    = 1'b0;
    ev         = 1'b0;
    sv         = 1'b0;
    tgt        = '0;
    sidx       = '0;
    res_status = ST_DONE;
    st_we      = 1'b0;
    st_waddr   = '0;
    dy_we      = 1'b0;
    dy_waddr   = '0;
    dy_wdata   = '0;
    st_wdata.id_high    = hi_r;
    st_wdata.id_low     = lo_r;
    st_wdata.prio       = prio_r;
    st_wdata.ttl        = ttl_r;
    st_wdata.to_self    = self_r;
    st_wdata.jitter     = jit;
    st_wdata.first_seen = now_r;
    if (cmd.commit) begin
      case (op_r)
        OP_INSERT: begin
          if (dup_r) begin
            res_status = ST_DUP;
          end else if (full && bf_r) begin
            tgt   = bs_r;
            ev    = 1'b1;
            place = 1'b1;
          end else if (!full && ff_r) begin
            tgt     = fs_r;
            place   = 1'b1;
            cnt_inc = 1'b1;
          end else begin
            res_status = ST_REJECT;
          end
          if (place) begin
            res_status = ST_STORED;
            sv         = 1'b1;
            sidx       = tgt;
            set_used   = 1'b1;
            st_we      = 1'b1;
            st_waddr   = tgt;
            dy_we      = 1'b1;
            dy_waddr   = tgt;
          end
        end
        OP_TICK: begin
          if (bf_r) begin
            sv   = 1'b1;
            sidx = bs_r;
            // clear a count at or above the forwarding limit once an hour has gone by
            if (bfwd_r >= limit_r && (now_r - blast_r) >= {10'd0, HOUR_MS}) begin
              dy_we    = 1'b1;
              dy_waddr = bs_r;
              dy_wdata = '{last_fwd: blast_r, fwd_cnt: 8'd0};
            end
          end
        end
        OP_REPORT: begin
          if (ok_r && rpt_in_range && used_r[rpt_idx]) begin
            dy_we    = 1'b1;
            dy_waddr = rpt_idx;
            dy_wdata = '{last_fwd: now_r, fwd_cnt: fwd_inc};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CAPACITY; i++) used_r[i] <= 1'b0;
      count_r <= '0;
    end else begin
      if (expire2) begin
        used_r[idx2_r] <= 1'b0;
        count_r        <= count_r - CW'(1);
      end else if (cnt_inc) begin
        count_r <= count_r + CW'(1);
      end
      if (set_used) used_r[tgt] <= 1'b1;
    end
  end

  // result register
  logic [SW+5:0] sl_ext, ev_ext;
  logic [CW+6:0] occ_ext, xc_ext;
  logic          out_valid_r;
  out_t          out_data_r;

  assign sl_ext  = {6'd0, sidx};
  assign ev_ext  = {6'd0, (ev ? bs_r : {SW{1'b0}})};
  assign occ_ext = {7'd0, count_r + CW'(cnt_inc)};
  assign xc_ext  = {7'd0, xcnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.commit;
    if (cmd.commit) begin
      out_data_r.status        <= res_status;
      out_data_r.slot_valid    <= sv;
      out_data_r.slot_out      <= sl_ext[5:0];
      out_data_r.evicted_valid <= ev;
      out_data_r.evicted_slot  <= ev_ext[5:0];
      out_data_r.expired_count <= xc_ext[6:0];
      out_data_r.occupancy     <= occ_ext[6:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY)) else $error("occupancy above capacity");
  a_out_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.commit)) else $error("result without commit");
  a_no_scan_at_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !v3_r && !v2_r) else $error("commit while scan in flight");

endmodule

// File: rtl/psft_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences scan, jitter wait, report read, commit.
// Depends on psft_pkg.
module psft_ctrl import psft_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int SW  = $clog2(CAPACITY),
  localparam int CTW = $clog2(CAPACITY + 4)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    command,
  output logic          busy,
  output dp_cmd_t       cmd,
  output logic [SW-1:0] scan_addr,
  input  dp_stat_t      stat
);

  state_t         state_r, state_nxt;
  logic [CTW-1:0] cnt_r, cnt_nxt;
  op_t            op_r, op_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          op_nxt = op_t'(command);
          case (op_t'(command))
            OP_INSERT, OP_TICK: state_nxt = S_SCAN;
            OP_REPORT:          state_nxt = S_RPT_RD;
            default:            state_nxt = S_COMMIT;
          endcase
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + CTW'(1);
        // last slot leaves the three-stage pipe
        if (cnt_r == CTW'(CAPACITY + 3)) state_nxt = S_WAIT_JIT;
      end
      S_WAIT_JIT: begin
        if (op_r != OP_INSERT || stat.jit_done) state_nxt = S_COMMIT;
      end
      S_RPT_RD: state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.load     = (state_r == S_IDLE) && start;
    cmd.scan_vld = (state_r == S_SCAN) && (cnt_r < CTW'(CAPACITY));
    cmd.rpt_rd   = state_r == S_RPT_RD;
    cmd.commit   = state_r == S_COMMIT;
    busy         = state_r != S_IDLE;
    scan_addr    = cnt_r[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      op_r    <= OP_NOP;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

// File: rtl/priority_store_forward_table_top.sv
`timescale 1ns / 1ps
// Top level of the priority store-and-forward slot table.
// Depends on psft_pkg, psft_ctrl and psft_dpath.

// Pulse start with an item while busy is low; the item is taken at that edge.
// One item is worked on at a time. An insert or a tick walks every slot of the
// table through a one-read-per-cycle memory port and a three-stage compare
// pipe; the id jitter hash and remainder run beside the scan, and an insert
// waits for them before it commits. A forward report reads its slot, then
// commits; a no-operation commits at once. The result on out_data is marked
// by out_valid, high for a single cycle, and cannot be stalled: capture it
// when out_valid is high. A new item may be started in the cycle that the
// result is shown. Write configuration only while busy is low and no result
// is pending; writes take effect at once.
// There is no clearing pass after reset: the used bits clear at once and slot
// fields are read only for used slots.
module priority_store_forward_table_top import psft_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int SW = $clog2(CAPACITY)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_t                   in_data,
  output logic                  out_valid,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [SW-1:0] scan_addr;

  // sequencing: advance through scan, jitter wait, report read and commit
  psft_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .command   (in_data.command),
    .busy      (busy),
    .cmd       (cmd),
    .scan_addr (scan_addr),
    .stat      (stat)
  );

  // slot storage, compare pipe and result register
  psft_dpath #(.CAPACITY(CAPACITY)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .scan_addr (scan_addr),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
